// ----- design/cdf_pkg.sv -----
// Shared constants, control struct and coefficient ROM for the complex decimating FIR.
package cdf_pkg;

    localparam int TAPS       = 37;
    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int FRAC_W     = COEF_W - 1;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 6;
    localparam int PHASE_W    = 4;
    localparam int FACTOR_W   = 5;
    localparam int FACTOR_MIN = 1;
    localparam int FACTOR_MAX = 16;
    localparam int FACTOR_RST = 4;

    // Per-channel datapath controls
    typedef struct packed {
        logic clear;    // zero the accumulator
        logic mul_en;   // register sample * coef
        logic acc_en;   // add product into accumulator
    } mac_ctrl_t;

    // Q1.17 low-pass taps, k = 0 is applied to the newest sample
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [ADDR_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            6'd0:    c = -18'sd37;
            6'd1:    c = -18'sd33;
            6'd2:    c = 18'sd46;
            6'd3:    c = 18'sd225;
            6'd4:    c = 18'sd462;
            6'd5:    c = 18'sd630;
            6'd6:    c = 18'sd543;
            6'd7:    c = 18'sd33;
            6'd8:    c = -18'sd925;
            6'd9:    c = -18'sd2113;
            6'd10:   c = -18'sd3042;
            6'd11:   c = -18'sd3054;
            6'd12:   c = -18'sd1530;
            6'd13:   c = 18'sd1847;
            6'd14:   c = 18'sd6877;
            6'd15:   c = 18'sd12794;
            6'd16:   c = 18'sd18411;
            6'd17:   c = 18'sd22445;
            6'd18:   c = 18'sd23913;
            6'd19:   c = 18'sd22445;
            6'd20:   c = 18'sd18411;
            6'd21:   c = 18'sd12794;
            6'd22:   c = 18'sd6877;
            6'd23:   c = 18'sd1847;
            6'd24:   c = -18'sd1530;
            6'd25:   c = -18'sd3054;
            6'd26:   c = -18'sd3042;
            6'd27:   c = -18'sd2113;
            6'd28:   c = -18'sd925;
            6'd29:   c = 18'sd33;
            6'd30:   c = 18'sd543;
            6'd31:   c = 18'sd630;
            6'd32:   c = 18'sd462;
            6'd33:   c = 18'sd225;
            6'd34:   c = 18'sd46;
            6'd35:   c = -18'sd33;
            6'd36:   c = -18'sd37;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- design/complex_decimating_fir.sv -----
// Top level of the complex decimating FIR: sample ring memory, tap sequencer, output register.
//
// Usage:
//   Input stream s_*: one complex sample per request, s_tdata = {in_q, in_i}.
//   Output stream m_*: one filtered sample per decimation period,
//   m_tdata = {out_q, out_i}, m_tuser = clipped (either channel saturated).
//   cfg_we / cfg_wdata set the decimation ratio (0 acts as 1, above 16 as 16);
//   write it only while the block is idle.
//   Every accepted sample goes into a 64-entry I/Q ring memory.
//   A sample that closes a decimation period starts a 37-tap sweep: one ring
//   read per cycle feeds one multiplier per channel; the sweep then drains
//   the read and product registers, then the round/saturate state loads
//   m_tdata. Samples that close no period only write the ring.
//   The single read port of the ring memory serialises the taps, so no new
//   sample is taken until the sweep is through.
//   s_tready is low during a sweep. A result waits in the output register
//   while m_tready is low; the next sample is still accepted, and its own
//   sweep stalls at the end until the output register is free.
//   Reset: ring reads as zeros (per-entry valid bits), write pointer and
//   phase count zero, factor 4, no result pending.
module complex_decimating_fir (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] in_i, [31:16] in_q
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] out_i, [31:16] out_q
    output logic        m_tuser,     // [0] clipped
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata    // decimation ratio
);

    localparam int AW = cdf_pkg::ADDR_W;
    localparam int SW = cdf_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [cdf_pkg::FACTOR_W-1:0] factor_reg;
    logic [cdf_pkg::FACTOR_W-1:0] factor_eff;
    logic [cdf_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic [AW-1:0]                base_reg, base_next;
    logic [AW-1:0]                tap_reg, tap_next;
    logic [AW-1:0]                k1_reg, k1_next;
    logic                         rd_v_reg, rd_v_next;
    logic                         rd_zero_reg, rd_zero_next;
    logic                         prod_v_reg;
    logic [cdf_pkg::LINE_DEPTH-1:0] valid_reg;

    logic                         accept;
    logic                         fire;
    logic [cdf_pkg::FACTOR_W-1:0] phase_inc;
    logic [AW-1:0]                raddr;
    logic [2*SW-1:0]              rdata;
    logic signed [SW-1:0]         samp_i, samp_q;
    logic signed [cdf_pkg::COEF_W-1:0] coef;
    logic signed [SW-1:0]         res_i, res_q;
    logic                         clip_i, clip_q;
    logic                         load_out;
    cdf_pkg::mac_ctrl_t           mac_ctrl;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // clamp factor to 1..16
    always_comb
    begin
        if (factor_reg < cdf_pkg::FACTOR_W'(cdf_pkg::FACTOR_MIN))
        begin
            factor_eff = cdf_pkg::FACTOR_W'(cdf_pkg::FACTOR_MIN);
        end
        else if (factor_reg > cdf_pkg::FACTOR_W'(cdf_pkg::FACTOR_MAX))
        begin
            factor_eff = cdf_pkg::FACTOR_W'(cdf_pkg::FACTOR_MAX);
        end
        else
        begin
            factor_eff = factor_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign phase_inc = {1'b0, phase_reg} + cdf_pkg::FACTOR_W'(1);
    assign fire      = (phase_inc >= factor_eff);
    assign raddr     = base_reg - tap_reg;
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    cdf_ram #(
        .WIDTH (2 * SW),
        .DEPTH (cdf_pkg::LINE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // never-written entries read as zero
    assign samp_i = rd_zero_reg ? '0 : rdata[SW-1:0];
    assign samp_q = rd_zero_reg ? '0 : rdata[2*SW-1:SW];
    assign coef   = cdf_pkg::coef_at(k1_reg);

    always_comb
    begin
        mac_ctrl.clear  = accept && fire;
        mac_ctrl.mul_en = rd_v_reg;
        mac_ctrl.acc_en = prod_v_reg;
    end

    cdf_mac u_mac_i (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (samp_i),
        .coef   (coef),
        .result (res_i),
        .clip   (clip_i)
    );

    cdf_mac u_mac_q (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (samp_q),
        .coef   (coef),
        .result (res_q),
        .clip   (clip_q)
    );

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        wp_next      = wp_reg;
        base_next    = base_reg;
        tap_next     = tap_reg;
        k1_next      = k1_reg;
        rd_v_next    = 1'b0;
        rd_zero_next = rd_zero_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next = wp_reg + AW'(1);
                    if (fire)
                    begin
                        phase_next = '0;
                        base_next  = wp_reg;
                        tap_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        phase_next = phase_inc[cdf_pkg::PHASE_W-1:0];
                    end
                end
            end
            ST_RUN:
            begin
                rd_v_next    = 1'b1;
                rd_zero_next = !valid_reg[raddr];
                k1_next      = tap_reg;
                tap_next     = tap_reg + AW'(1);
                if (tap_reg == AW'(cdf_pkg::TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            factor_reg   <= cdf_pkg::FACTOR_W'(cdf_pkg::FACTOR_RST);
            phase_reg    <= '0;
            wp_reg       <= '0;
            base_reg     <= '0;
            tap_reg      <= '0;
            k1_reg       <= '0;
            rd_v_reg     <= 1'b0;
            rd_zero_reg  <= 1'b1;
            prod_v_reg   <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            wp_reg      <= wp_next;
            base_reg    <= base_next;
            tap_reg     <= tap_next;
            k1_reg      <= k1_next;
            rd_v_reg    <= rd_v_next;
            rd_zero_reg <= rd_zero_next;
            prod_v_reg  <= rd_v_reg;
            if (cfg_we)
            begin
                factor_reg <= cfg_wdata;
            end
            if (accept)
            begin
                valid_reg[wp_reg] <= 1'b1;
            end
            // output payload and valid
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {res_q, res_i};
                m_tuser_reg  <= clip_i || clip_q;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // products are all in the accumulator before rounding starts
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!rd_v_reg && !prod_v_reg))
        else $error("result taken with taps still in flight");

    // a period-closing sample starts the tap sweep at the newest entry
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fire) |=> (state_reg == ST_RUN && tap_reg == '0
                              && base_reg == $past(wp_reg)))
        else $error("tap sweep did not start on period boundary");

    // a new result only follows the round stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == ST_DONE))
        else $error("result valid raised outside round stage");

    // the ring pointer advances only on accepted samples
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(wp_reg))
        else $error("write pointer moved without a sample");
`endif

endmodule

// ----- design/cdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cdf_mac.sv -----
// One-channel multiply-accumulate with round-to-nearest and 16-bit saturation.
module cdf_mac (
    input  logic                                 clk,
    input  cdf_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [cdf_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [cdf_pkg::COEF_W-1:0]    coef,
    output logic signed [cdf_pkg::SAMPLE_W-1:0]  result,
    output logic                                 clip
);

    localparam logic signed [cdf_pkg::ACC_W-1:0] HALF =
        cdf_pkg::ACC_W'(1) <<< (cdf_pkg::FRAC_W - 1);
    localparam logic signed [cdf_pkg::ACC_W-1:0] SAT_HI =
        cdf_pkg::ACC_W'((1 << (cdf_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [cdf_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - cdf_pkg::ACC_W'(1);

    logic signed [cdf_pkg::PROD_W-1:0] prod_reg;
    logic signed [cdf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [cdf_pkg::ACC_W-1:0]  rounded;
    logic signed [cdf_pkg::ACC_W-1:0]  shifted;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= sample * coef;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg
                + {{(cdf_pkg::ACC_W - cdf_pkg::PROD_W){prod_reg[cdf_pkg::PROD_W-1]}}, prod_reg};
        end
    end

    // add half an LSB, then floor by arithmetic shift
    assign rounded = acc_reg + HALF;
    assign shifted = rounded >>> cdf_pkg::FRAC_W;

    always_comb
    begin
        clip = 1'b0;
        if (shifted > SAT_HI)
        begin
            result = SAT_HI[cdf_pkg::SAMPLE_W-1:0];
            clip   = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[cdf_pkg::SAMPLE_W-1:0];
            clip   = 1'b1;
        end
        else
        begin
            result = shifted[cdf_pkg::SAMPLE_W-1:0];
        end
    end

endmodule
